// ===== sv/fqps_pkg.sv =====
package fqps_pkg;

  // Header bytes that open a frame
  localparam logic [7:0] HdrFirst  = 8'hAA;
  localparam logic [7:0] HdrSecond = 8'h55;

  // Field widths
  localparam int unsigned ByteW  = 8;
  localparam int unsigned EventW = 3;
  localparam int unsigned SumW   = 16;

  // Frame event codes
  typedef enum logic [EventW-1:0] {
    EV_NONE     = 3'd0,
    EV_BADHDR   = 3'd1,
    EV_BADSUM   = 3'd2,
    EV_UNSUP    = 3'd3,
    EV_REGISTER = 3'd4,
    EV_ASSIGN   = 3'd5,
    EV_REMOVE   = 3'd6,
    EV_INFO     = 3'd7
  } frame_event_e;

  // Control and function codes of the supported requests
  localparam logic [7:0] CtrlMgmt  = 8'd0;
  localparam logic [7:0] CtrlQuery = 8'd1;
  localparam logic [7:0] FuncReg   = 8'd0;
  localparam logic [7:0] FuncAsgn  = 8'd1;
  localparam logic [7:0] FuncRem   = 8'd2;
  localparam logic [7:0] FuncInfo  = 8'd1;

  // One result word
  typedef struct packed {
    frame_event_e     frame_event;
    logic [ByteW-1:0] payload_length;
    logic [ByteW-1:0] function_value;
    logic [ByteW-1:0] control_value;
    logic [ByteW-1:0] target_address;
    logic [ByteW-1:0] source_address;
  } result_t;

  // Classify a good frame by its control and function codes
  function automatic frame_event_e classify(input logic [ByteW-1:0] ctrl,
                                            input logic [ByteW-1:0] func);
    frame_event_e ev;
    ev = EV_UNSUP;
    if (ctrl == CtrlMgmt) begin
      if (func == FuncReg) ev = EV_REGISTER;
      else if (func == FuncAsgn) ev = EV_ASSIGN;
      else if (func == FuncRem) ev = EV_REMOVE;
    end else if (ctrl == CtrlQuery && func == FuncInfo) begin
      ev = EV_INFO;
    end
    return ev;
  endfunction

endpackage

// ===== sv/fqps_parser.sv =====
module fqps_parser
  import fqps_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,   // consume byte_i this cycle
  input  logic [ByteW-1:0] byte_i,
  output result_t          result_o  // result of the byte consumed this cycle
);

  typedef enum logic [3:0] {
    PH_HUNT = 4'd0,
    PH_HDR2 = 4'd1,
    PH_SRC  = 4'd2,
    PH_DST  = 4'd3,
    PH_CTRL = 4'd4,
    PH_FUNC = 4'd5,
    PH_LEN  = 4'd6,
    PH_PAY  = 4'd7,
    PH_CSH  = 4'd8,
    PH_CSL  = 4'd9
  } phase_e;

  phase_e           phase_q, phase_d;
  logic [ByteW-1:0] left_q, left_d;
  logic [SumW-1:0]  sum_q, sum_d;
  logic [ByteW-1:0] src_q, src_d;
  logic [ByteW-1:0] dst_q, dst_d;
  logic [ByteW-1:0] ctrl_q, ctrl_d;
  logic [ByteW-1:0] func_q, func_d;
  logic [ByteW-1:0] len_q, len_d;
  logic [ByteW-1:0] sumhi_q, sumhi_d;

  logic [SumW-1:0]  sum_add;
  logic [ByteW-1:0] left_dec;
  frame_event_e     ev;
  logic             carry;

  assign sum_add  = sum_q + {{(SumW-ByteW){1'b0}}, byte_i};
  assign left_dec = left_q - 8'd1;

  // Next state and result for one byte
  always_comb begin
    phase_d = phase_q;
    left_d  = left_q;
    sum_d   = sum_q;
    src_d   = src_q;
    dst_d   = dst_q;
    ctrl_d  = ctrl_q;
    func_d  = func_q;
    len_d   = len_q;
    sumhi_d = sumhi_q;
    ev      = EV_NONE;
    carry   = 1'b0;
    unique case (phase_q)
      PH_HUNT: begin
        if (byte_i == HdrFirst) begin
          sum_d   = {{(SumW-ByteW){1'b0}}, byte_i};
          phase_d = PH_HDR2;
        end
      end
      PH_HDR2: begin
        if (byte_i == HdrSecond) begin
          sum_d   = sum_add;
          phase_d = PH_SRC;
        end else begin
          ev      = EV_BADHDR;
          phase_d = PH_HUNT;
        end
      end
      PH_SRC: begin
        src_d = byte_i; sum_d = sum_add; phase_d = PH_DST;
      end
      PH_DST: begin
        dst_d = byte_i; sum_d = sum_add; phase_d = PH_CTRL;
      end
      PH_CTRL: begin
        ctrl_d = byte_i; sum_d = sum_add; phase_d = PH_FUNC;
      end
      PH_FUNC: begin
        func_d = byte_i; sum_d = sum_add; phase_d = PH_LEN;
      end
      PH_LEN: begin
        len_d   = byte_i;
        left_d  = byte_i;
        sum_d   = sum_add;
        phase_d = (byte_i == '0) ? PH_CSH : PH_PAY;
      end
      PH_PAY: begin
        sum_d  = sum_add;
        left_d = left_dec;
        if (left_dec == '0) phase_d = PH_CSH;
      end
      PH_CSH: begin
        sumhi_d = byte_i; phase_d = PH_CSL;
      end
      PH_CSL: begin
        ev      = ({sumhi_q, byte_i} == sum_q) ? classify(ctrl_q, func_q) : EV_BADSUM;
        carry   = 1'b1;
        phase_d = PH_HUNT;
      end
      default: phase_d = PH_HUNT;
    endcase
  end

  // Result word: frame fields only for a finished frame
  always_comb begin
    result_o.frame_event    = ev;
    result_o.source_address = carry ? src_q  : '0;
    result_o.target_address = carry ? dst_q  : '0;
    result_o.control_value  = carry ? ctrl_q : '0;
    result_o.function_value = carry ? func_q : '0;
    result_o.payload_length = carry ? len_q  : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      left_q  <= '0;
      sum_q   <= '0;
      src_q   <= '0;
      dst_q   <= '0;
      ctrl_q  <= '0;
      func_q  <= '0;
      len_q   <= '0;
      sumhi_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      left_q  <= left_d;
      sum_q   <= sum_d;
      src_q   <= src_d;
      dst_q   <= dst_d;
      ctrl_q  <= ctrl_d;
      func_q  <= func_d;
      len_q   <= len_d;
      sumhi_q <= sumhi_d;
    end
  end

endmodule

// ===== sv/framed_query_parser_sum16.sv =====
// Throughput: one byte per cycle while the output is not stalled; every byte gives exactly one result word.
// The parser step sits between the input register and the output register,
// and a stalled output still lets one more byte be taken into the input register.
// Reset (rst_ni low, asynchronous) empties both registers and returns the
// parser to hunting for the first header byte with all held fields zero.
module framed_query_parser_sum16
  import fqps_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [7:0] source_address, [15:8] target_address,
                                      // [23:16] control_value, [31:24] function_value,
                                      // [39:32] payload_length
  output logic [2:0]  m_axis_tuser    // [2:0] frame_event
);

  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;
  logic             out_valid_q;
  result_t          out_q;
  result_t          step_res;
  logic             advance;
  logic             step;

  // Pipeline moves when the output register is free or being drained
  assign advance       = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  fqps_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .byte_i   (in_byte_q),
    .result_o (step_res)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= step_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.frame_event;
  assign m_axis_tdata  = {out_q.payload_length, out_q.function_value,
                          out_q.control_value, out_q.target_address,
                          out_q.source_address};

  // Checks
  a_tready_low_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && out_valid_q && !m_axis_tready))
    else $error("input stalled while pipeline has room");

  a_step_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_q)
    else $error("parsed word lost before output register");

  a_no_frame_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == EV_NONE || m_axis_tuser == EV_BADHDR))
      |-> (m_axis_tdata == '0))
    else $error("frame fields set without a finished frame");

  a_accept_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!in_valid_q && !out_valid_q) |-> s_axis_tready)
    else $error("empty pipeline refuses input");

endmodule

// ===== dv/fqps_checker.sv =====
`timescale 1ns / 1ps

// Watches both stream channels, runs its own copy of the frame parser on every
// accepted byte and checks each result word against the oldest prediction.
module fqps_checker
  import fqps_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  input  logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,   // [7:0] rx_byte
  input  logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  input  logic [39:0]       m_axis_tdata,   // [7:0] source_address, [15:8] target_address,
                                            // [23:16] control_value, [31:24] function_value,
                                            // [39:32] payload_length
  input  logic [2:0]        m_axis_tuser,   // [2:0] frame_event
  output int unsigned       error_count_o,
  output int unsigned       words_pending_o,
  output int unsigned       words_checked_o,
  output int unsigned       frames_ok_o,
  output int unsigned       frames_bad_o
);

  // Where the parser stands inside a frame
  typedef enum logic [3:0] {
    HUNT, HDR2, SRC, DST, CTRL, FUNC, LEN, PAYLOAD, SUM_HI, SUM_LO
  } parse_phase_e;

  parse_phase_e     phase;
  logic [7:0]       bytes_left;
  logic [SumW-1:0]  running_sum;
  logic [7:0]       src_q, dst_q, ctrl_q, func_q, len_q, sum_hi_q;
  result_t          pending_words[$];

  // Request kind of a frame whose checksum matched
  function automatic frame_event_e request_kind(input logic [7:0] ctrl, input logic [7:0] func);
    case ({ctrl, func})
      {CtrlMgmt, FuncReg}:   return EV_REGISTER;
      {CtrlMgmt, FuncAsgn}:  return EV_ASSIGN;
      {CtrlMgmt, FuncRem}:   return EV_REMOVE;
      {CtrlQuery, FuncInfo}: return EV_INFO;
      default:               return EV_UNSUP;
    endcase
  endfunction

  // Advance the parser by one byte and form the word it should produce
  task automatic parse_byte(input logic [7:0] b, output result_t word);
    logic frame_done;
    word = '0;
    word.frame_event = EV_NONE;
    frame_done = 1'b0;
    case (phase)
      HUNT: begin
        if (b == HdrFirst) begin
          running_sum = SumW'(b);
          phase = HDR2;
        end
      end
      HDR2: begin
        if (b == HdrSecond) begin
          running_sum += SumW'(b);
          phase = SRC;
        end else begin
          // the offending byte is dropped, not taken as a new first header
          word.frame_event = EV_BADHDR;
          phase = HUNT;
        end
      end
      SRC: begin
        src_q = b;
        running_sum += SumW'(b);
        phase = DST;
      end
      DST: begin
        dst_q = b;
        running_sum += SumW'(b);
        phase = CTRL;
      end
      CTRL: begin
        ctrl_q = b;
        running_sum += SumW'(b);
        phase = FUNC;
      end
      FUNC: begin
        func_q = b;
        running_sum += SumW'(b);
        phase = LEN;
      end
      LEN: begin
        len_q = b;
        bytes_left = b;
        running_sum += SumW'(b);
        // empty payload goes straight to the checksum
        phase = (b == 8'd0) ? SUM_HI : PAYLOAD;
      end
      PAYLOAD: begin
        running_sum += SumW'(b);
        bytes_left--;
        if (bytes_left == 8'd0) phase = SUM_HI;
      end
      SUM_HI: begin
        sum_hi_q = b;
        phase = SUM_LO;
      end
      SUM_LO: begin
        word.frame_event = ({sum_hi_q, b} == running_sum) ? request_kind(ctrl_q, func_q)
                                                          : EV_BADSUM;
        frame_done = 1'b1;
        phase = HUNT;
      end
      default: phase = HUNT;
    endcase
    if (frame_done) begin
      word.source_address = src_q;
      word.target_address = dst_q;
      word.control_value  = ctrl_q;
      word.function_value = func_q;
      word.payload_length = len_q;
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count_o++;
    end
  endtask

  // Predict on accepted bytes, compare on accepted result words
  always @(posedge clk_i or negedge rst_ni) begin
    result_t want_word, got_word, next_word;
    if (!rst_ni) begin
      phase       = HUNT;
      bytes_left  = '0;
      running_sum = '0;
      src_q       = '0;
      dst_q       = '0;
      ctrl_q      = '0;
      func_q      = '0;
      len_q       = '0;
      sum_hi_q    = '0;
      pending_words.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_word.source_address = m_axis_tdata[7:0];
        got_word.target_address = m_axis_tdata[15:8];
        got_word.control_value  = m_axis_tdata[23:16];
        got_word.function_value = m_axis_tdata[31:24];
        got_word.payload_length = m_axis_tdata[39:32];
        got_word.frame_event    = frame_event_e'(m_axis_tuser);
        if (pending_words.size() == 0) begin
          $error("result word with no byte behind it: frame_event %0d", m_axis_tuser);
          error_count_o++;
        end else begin
          want_word = pending_words.pop_front();
          check_field("frame_event", 8'(want_word.frame_event), 8'(m_axis_tuser));
          check_field("source_address", want_word.source_address, got_word.source_address);
          check_field("target_address", want_word.target_address, got_word.target_address);
          check_field("control_value", want_word.control_value, got_word.control_value);
          check_field("function_value", want_word.function_value, got_word.function_value);
          check_field("payload_length", want_word.payload_length, got_word.payload_length);
          words_checked_o++;
          case (want_word.frame_event) inside
            EV_NONE:             ;
            EV_BADHDR, EV_BADSUM: frames_bad_o++;
            default:             frames_ok_o++;
          endcase
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        parse_byte(s_axis_tdata, next_word);
        pending_words.push_back(next_word);
      end
    end
    words_pending_o = pending_words.size();
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import fqps_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;     // [7:0] rx_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;          // [7:0] source_address ... [39:32] payload_length
  logic [2:0]  m_axis_tuser;          // [2:0] frame_event

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned bytes_sent = 0;
  int unsigned error_count, words_pending, words_checked, frames_ok, frames_bad;

  framed_query_parser_sum16 uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  fqps_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .m_axis_tuser    (m_axis_tuser),
    .error_count_o   (error_count),
    .words_pending_o (words_pending),
    .words_checked_o (words_checked),
    .frames_ok_o     (frames_ok),
    .frames_bad_o    (frames_bad)
  );

  // 12 ns clock
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Result side: random backpressure
  always @(posedge clk_i) begin
    m_axis_tready <= rst_ni && ($urandom_range(99) >= rx_idle_pct);
  end

  // Offer one byte, with random gaps ahead of it, and wait until it is taken
  task automatic send_byte(input logic [7:0] b);
    logic took;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do begin
      @(negedge clk_i);
      took = s_axis_tready;
      @(posedge clk_i);
    end while (!took);
    bytes_sent++;
  endtask

  // Whole frame with random payload; corrupt flips checksum bits
  task automatic send_frame(input logic [7:0] src, input logic [7:0] dst,
                            input logic [7:0] ctrl, input logic [7:0] func,
                            input logic [7:0] len, input logic corrupt);
    logic [7:0]      frame_bytes[$];
    logic [SumW-1:0] sum;
    frame_bytes = '{HdrFirst, HdrSecond, src, dst, ctrl, func, len};
    repeat (len) frame_bytes.push_back(8'($urandom_range(255)));
    sum = '0;
    foreach (frame_bytes[i]) sum += SumW'(frame_bytes[i]);
    if (corrupt) sum ^= SumW'($urandom_range(65535, 1));
    frame_bytes.push_back(sum[15:8]);
    frame_bytes.push_back(sum[7:0]);
    foreach (frame_bytes[i]) send_byte(frame_bytes[i]);
  endtask

  // Mostly supported requests, some near misses and arbitrary codes
  task automatic random_frame(input logic corrupt);
    logic [7:0] ctrl, func, len;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 60) begin
      case ($urandom_range(3))
        0:       {ctrl, func} = {CtrlMgmt, FuncReg};
        1:       {ctrl, func} = {CtrlMgmt, FuncAsgn};
        2:       {ctrl, func} = {CtrlMgmt, FuncRem};
        default: {ctrl, func} = {CtrlQuery, FuncInfo};
      endcase
    end else if (pick < 80) begin
      ctrl = 8'($urandom_range(2));
      func = 8'($urandom_range(3));
    end else begin
      ctrl = 8'($urandom_range(255));
      func = 8'($urandom_range(255));
    end
    len = ($urandom_range(99) < 85) ? 8'($urandom_range(6)) : 8'($urandom_range(40));
    send_frame(8'($urandom_range(255)), 8'($urandom_range(255)), ctrl, func, len, corrupt);
  endtask

  // Mix of good frames, bad checksums, bad headers, noise and cut-off frames
  task automatic random_traffic(input int unsigned budget);
    int unsigned stop_at, pick;
    logic [7:0] b;
    stop_at = bytes_sent + budget;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        random_frame(1'b0);
      end else if (pick < 80) begin
        random_frame(1'b1);
      end else if (pick < 88) begin
        b = 8'($urandom_range(255));
        if (b == HdrSecond) b = ~b;
        send_byte(HdrFirst);
        send_byte(b);
      end else if (pick < 95) begin
        repeat ($urandom_range(4, 1)) send_byte(8'($urandom_range(255)));
      end else begin
        send_byte(HdrFirst);
        send_byte(HdrSecond);
        repeat ($urandom_range(5, 1)) send_byte(8'($urandom_range(255)));
      end
    end
  endtask

  // Hold the input off until every result word has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (words_pending != 0);
    @(posedge clk_i);
  endtask

  // Stimulus and verdict
  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: noise, doubled first header, empty and one-byte frames
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(HdrFirst);
    send_byte(HdrFirst);
    send_frame(8'hFF, 8'h00, CtrlMgmt, FuncReg, 8'd0, 1'b0);
    send_frame(8'h00, 8'hFF, CtrlQuery, FuncInfo, 8'd1, 1'b0);

    tx_idle_pct = 34;
    rx_idle_pct = 77;
    random_traffic(180);
    drain();

    tx_idle_pct = 77;
    rx_idle_pct = 34;
    random_traffic(180);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_traffic(180);
    // longest payload the length byte allows
    send_frame(8'($urandom_range(255)), 8'($urandom_range(255)), CtrlMgmt, FuncRem,
               8'd255, 1'b0);

    drain();
    repeat (10) @(posedge clk_i);

    $display("Sent %0d bytes and checked %0d result words under changing backpressure.",
             bytes_sent, words_checked);
    $display("Frames decoded: %0d, rejected on header or checksum: %0d.",
             frames_ok, frames_bad);
    if (error_count == 0 && words_pending == 0) begin
      $display("PASS framed_query_parser_sum16");
    end else begin
      $display("FAIL framed_query_parser_sum16");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("FAIL framed_query_parser_sum16");
    $finish;
  end

endmodule

// ===== framed_query_parser_sum16.f =====
sv/fqps_pkg.sv
sv/fqps_parser.sv
sv/framed_query_parser_sum16.sv
dv/fqps_checker.sv
dv/testbench.sv
